// ===== src/ght_pkg.sv =====
// Shared types and constants for the generational handle table.
`timescale 1ns / 1ps
package ght_pkg;

   localparam int ID_W         = 8;
   localparam int GEN_W        = 8;
   localparam int OUT_CNT_W    = 16;
   localparam int GROUP_W      = 16;
   localparam int DEF_SLOTS    = 256;
   localparam int DEF_REF_BITS = 16;
   localparam logic [ID_W-1:0] NULL_ID = '1;

   typedef enum logic [2:0] {
      REQ_ALLOC   = 3'd0,
      REQ_FREE    = 3'd1,
      REQ_ACQUIRE = 3'd2,
      REQ_RELEASE = 3'd3,
      REQ_CHECK   = 3'd4,
      REQ_READ    = 3'd5
   } req_code_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_BADGEN  = 3'd1,
      ST_REFD    = 3'd2,
      ST_FREE    = 3'd3,
      ST_FULL    = 3'd4,
      ST_NULL    = 3'd5,
      ST_NOTHELD = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SRCH,
      S_PICK,
      S_READ,
      S_EXEC
   } state_type;

   typedef struct packed {
      logic load;
      logic srch;
      logic pick;
      logic rd;
      logic exec;
   } cmd_type;

endpackage

// ===== src/ght_ctrl.sv =====
// Controller state machine for the generational handle table.
`timescale 1ns / 1ps
module ght_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [2:0]       req_type,
   output logic             req_ready,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output ght_pkg::cmd_type cmd
);
   import ght_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            // Nothing is taken while reset is held.
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.load = 1'b1;
               case (req_code_type'(req_type))
                  REQ_ALLOC:   state_in = S_SRCH;
                  REQ_FREE,
                  REQ_ACQUIRE,
                  REQ_RELEASE,
                  REQ_CHECK,
                  REQ_READ:    state_in = S_READ;
                  default:     state_in = S_IDLE;
               endcase
            end
         end
         S_SRCH: begin
            cmd.srch = 1'b1;
            state_in = S_PICK;
         end
         S_PICK: begin
            cmd.pick = 1'b1;
            state_in = S_READ;
         end
         S_READ: begin
            cmd.rd   = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            // The result register must be empty or draining before it is loaded.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.exec = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.exec ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   assign rsp_valid    = rsp_valid_ff;

endmodule

// ===== src/ght_dp.sv =====
// Datapath for the generational handle table: slot memories, free marks and result register.
`timescale 1ns / 1ps
module ght_dp #(
   parameter int SLOTS    = ght_pkg::DEF_SLOTS,
   parameter int REF_BITS = ght_pkg::DEF_REF_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ght_pkg::cmd_type               cmd,
   input  logic [2:0]                     req_type,
   input  logic [ght_pkg::ID_W-1:0]       req_slot_id,
   input  logic [ght_pkg::GEN_W-1:0]      req_handle_gen,
   input  logic                           req_batch_last,
   output logic [2:0]                     rsp_status,
   output logic [ght_pkg::ID_W-1:0]       rsp_out_slot,
   output logic [ght_pkg::GEN_W-1:0]      rsp_out_gen,
   output logic [ght_pkg::OUT_CNT_W-1:0]  rsp_ref_count_out,
   output logic                           rsp_first_acquire,
   output logic                           rsp_last_release,
   output logic                           rsp_batch_last_out
);
   import ght_pkg::*;

   localparam int DEPTH = (SLOTS < 256) ? SLOTS : 256;
   localparam int LIMIT = (SLOTS < 255) ? SLOTS : 255;
   localparam int AW    = $clog2(DEPTH);
   localparam int UW    = $clog2(LIMIT + 1);
   localparam int NG    = (DEPTH + GROUP_W - 1) / GROUP_W;
   localparam int GW    = (NG > 1) ? $clog2(NG) : 1;
   localparam int LW    = $clog2(GROUP_W);
   localparam int PADW  = NG * GROUP_W;
   localparam int CW    = ID_W + 1;

   // Request registers
   req_code_type          type_ff;
   logic [ID_W-1:0]       slot_ff;
   logic [GEN_W-1:0]      hgen_ff;
   logic                  blast_ff;

   // Free marks and fill count
   logic [DEPTH-1:0]      free_ff;
   logic [UW-1:0]         used_ff;

   // Search registers
   logic [GW-1:0]         grp_ff;
   logic                  found_ff;
   logic [AW-1:0]         alloc_idx_ff;

   // Slot memories
   logic [GEN_W-1:0]      gen_mem [DEPTH];
   logic [REF_BITS-1:0]   cnt_mem [DEPTH];
   logic [GEN_W-1:0]      rd_gen_ff;
   logic [REF_BITS-1:0]   rd_cnt_ff;

   // Result register
   status_type            st_ff;
   logic [ID_W-1:0]       oslot_ff;
   logic [GEN_W-1:0]      ogen_ff;
   logic [REF_BITS-1:0]   ocnt_ff;
   logic                  first_ff;
   logic                  last_ff;
   logic                  oblast_ff;

   logic [PADW-1:0]       free_pad;
   logic [NG-1:0]         grp_any;
   logic [GW-1:0]         grp_sel;
   logic [GROUP_W-1:0]    grp_word;
   logic [LW-1:0]         low_sel;
   logic [AW-1:0]         rd_addr;
   logic [AW-1:0]         id_addr;

   status_type            st;
   logic [ID_W-1:0]       o_slot;
   logic [GEN_W-1:0]      o_gen;
   logic [REF_BITS-1:0]   o_cnt;
   logic                  o_first;
   logic                  o_last;
   logic                  mem_we;
   logic [AW-1:0]         wr_addr;
   logic [GEN_W-1:0]      gen_new;
   logic [REF_BITS-1:0]   cnt_new;
   logic                  set_free;
   logic                  clr_free;
   logic                  bump_used;
   logic                  known;
   logic                  room;

   assign id_addr = slot_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff  <= req_code_type'(req_type);
         slot_ff  <= req_slot_id;
         hgen_ff  <= req_handle_gen;
         blast_ff <= req_batch_last;
      end
   end

   // Two-level search for the lowest free slot.
   assign free_pad = PADW'(free_ff);

   always_comb begin
      for (int g = 0; g < NG; g++) begin
         grp_any[g] = |free_pad[g*GROUP_W +: GROUP_W];
      end
   end

   always_comb begin
      grp_sel = '0;
      for (int g = NG - 1; g >= 0; g--) begin
         if (grp_any[g]) begin
            grp_sel = GW'(g);
         end
      end
   end

   assign grp_word = free_pad[grp_ff*GROUP_W +: GROUP_W];

   always_comb begin
      low_sel = '0;
      for (int b = GROUP_W - 1; b >= 0; b--) begin
         if (grp_word[b]) begin
            low_sel = LW'(b);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.srch) begin
         grp_ff   <= grp_sel;
         found_ff <= |grp_any;
      end
      if (cmd.pick) begin
         alloc_idx_ff <= AW'({grp_ff, low_sel});
      end
   end

   // Memory read, one address per request.
   assign rd_addr = (type_ff == REQ_ALLOC) ? alloc_idx_ff : id_addr;

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rd_gen_ff <= gen_mem[rd_addr];
         rd_cnt_ff <= cnt_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && mem_we) begin
         gen_mem[wr_addr] <= gen_new;
         cnt_mem[wr_addr] <= cnt_new;
      end
   end

   assign known = CW'(slot_ff) < CW'(used_ff);
   assign room  = CW'(used_ff) < CW'(LIMIT);

   always_comb begin
      st        = ST_OK;
      o_slot    = slot_ff;
      o_gen     = '0;
      o_cnt     = '0;
      o_first   = 1'b0;
      o_last    = 1'b0;
      mem_we    = 1'b0;
      wr_addr   = id_addr;
      gen_new   = rd_gen_ff;
      cnt_new   = rd_cnt_ff;
      set_free  = 1'b0;
      clr_free  = 1'b0;
      bump_used = 1'b0;
      case (type_ff)
         REQ_ALLOC: begin
            if (found_ff) begin
               o_slot   = ID_W'(alloc_idx_ff);
               gen_new  = rd_gen_ff + 1'b1;
               cnt_new  = '0;
               o_gen    = gen_new;
               mem_we   = 1'b1;
               wr_addr  = alloc_idx_ff;
               clr_free = 1'b1;
            end else if (room) begin
               o_slot    = ID_W'(used_ff);
               gen_new   = '0;
               cnt_new   = '0;
               mem_we    = 1'b1;
               wr_addr   = AW'(used_ff);
               bump_used = 1'b1;
            end else begin
               st     = ST_FULL;
               o_slot = '0;
            end
         end
         REQ_READ: begin
            if (!known) begin
               st = ST_BADGEN;
            end else begin
               o_gen = rd_gen_ff;
               o_cnt = rd_cnt_ff;
            end
         end
         REQ_FREE, REQ_ACQUIRE, REQ_RELEASE, REQ_CHECK: begin
            if (slot_ff == NULL_ID) begin
               st = ST_NULL;
            end else if (!known) begin
               st = ST_BADGEN;
            end else if (rd_gen_ff != hgen_ff) begin
               st    = ST_BADGEN;
               o_gen = rd_gen_ff;
               o_cnt = rd_cnt_ff;
            end else begin
               o_gen = rd_gen_ff;
               o_cnt = rd_cnt_ff;
               case (type_ff)
                  REQ_FREE: begin
                     if (rd_cnt_ff != '0) begin
                        st = ST_REFD;
                     end else if (free_ff[id_addr]) begin
                        st = ST_FREE;
                     end else begin
                        gen_new  = rd_gen_ff + 1'b1;
                        o_gen    = gen_new;
                        mem_we   = 1'b1;
                        set_free = 1'b1;
                     end
                  end
                  REQ_ACQUIRE: begin
                     // The count sticks at its largest value.
                     if (rd_cnt_ff != '1) begin
                        cnt_new = rd_cnt_ff + 1'b1;
                        o_cnt   = cnt_new;
                        o_first = (rd_cnt_ff == '0);
                        mem_we  = 1'b1;
                     end
                  end
                  REQ_RELEASE: begin
                     if (rd_cnt_ff == '0) begin
                        st    = ST_NOTHELD;
                        o_cnt = '0;
                     end else begin
                        cnt_new = rd_cnt_ff - 1'b1;
                        o_cnt   = cnt_new;
                        o_last  = (cnt_new == '0);
                        mem_we  = 1'b1;
                     end
                  end
                  default: begin
                     if (free_ff[id_addr]) begin
                        st = ST_FREE;
                     end
                  end
               endcase
            end
         end
         default: st = ST_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= '0;
         used_ff <= '0;
      end else if (cmd.exec) begin
         if (set_free) begin
            free_ff[wr_addr] <= 1'b1;
         end
         if (clr_free) begin
            free_ff[wr_addr] <= 1'b0;
         end
         if (bump_used) begin
            used_ff <= used_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         st_ff     <= st;
         oslot_ff  <= o_slot;
         ogen_ff   <= o_gen;
         ocnt_ff   <= o_cnt;
         first_ff  <= o_first;
         last_ff   <= o_last;
         oblast_ff <= blast_ff;
      end
   end

   assign rsp_status         = st_ff;
   assign rsp_out_slot       = oslot_ff;
   assign rsp_out_gen        = ogen_ff;
   assign rsp_ref_count_out  = OUT_CNT_W'(ocnt_ff);
   assign rsp_first_acquire  = first_ff;
   assign rsp_last_release   = last_ff;
   assign rsp_batch_last_out = oblast_ff;

endmodule

// ===== src/generational_handle_table.sv =====
// Top level of the generational handle table.
`timescale 1ns / 1ps
// The block keeps a table of slots, each with a generation, a free mark and a
// reference count. A request transaction on the req_ channel carries a request
// code, a handle (slot id and generation) and a batch marker; each known request
// yields exactly one result transaction on the rsp_ channel. Codes 6 and 7 are
// accepted and dropped without a result.
// Allocate passes from acceptance through the two-level search of the free marks
// (group search, then bit pick), the memory read and the update before the idle
// state can accept again. All other requests pass through the read, the update and
// the idle state that accepts. The result appears in the cycle after the update
// and is held in an output register, so the next request is accepted while a
// result waits. If the receiver stalls, the update of the next request waits in
// place until the output register is taken.
// A synchronous, active-high reset empties the table at once: the fill count
// and free marks clear, and slot memories need no clearing because no entry
// is read before it has been appended.
module generational_handle_table #(
   parameter int SLOTS    = ght_pkg::DEF_SLOTS,
   parameter int REF_BITS = ght_pkg::DEF_REF_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [2:0]                     req_type,
   input  logic [ght_pkg::ID_W-1:0]       req_slot_id,
   input  logic [ght_pkg::GEN_W-1:0]      req_handle_gen,
   input  logic                           req_batch_last,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [2:0]                     rsp_status,
   output logic [ght_pkg::ID_W-1:0]       rsp_out_slot,
   output logic [ght_pkg::GEN_W-1:0]      rsp_out_gen,
   output logic [ght_pkg::OUT_CNT_W-1:0]  rsp_ref_count_out,
   output logic                           rsp_first_acquire,
   output logic                           rsp_last_release,
   output logic                           rsp_batch_last_out
);
   import ght_pkg::*;

   // Command strobes from the controller to the datapath.
   cmd_type cmd;

   ght_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // The datapath holds the slot memories, the free marks, the fill count and
   // the output register. Apart from reset, it acts only on the controller's strobes.
   ght_dp #(
      .SLOTS    (SLOTS),
      .REF_BITS (REF_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_type           (req_type),
      .req_slot_id        (req_slot_id),
      .req_handle_gen     (req_handle_gen),
      .req_batch_last     (req_batch_last),
      .rsp_status         (rsp_status),
      .rsp_out_slot       (rsp_out_slot),
      .rsp_out_gen        (rsp_out_gen),
      .rsp_ref_count_out  (rsp_ref_count_out),
      .rsp_first_acquire  (rsp_first_acquire),
      .rsp_last_release   (rsp_last_release),
      .rsp_batch_last_out (rsp_batch_last_out)
   );

`ifndef NO_ASSERTIONS
   // The controller issues at most one step at a time.
   a_one_cmd : assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.srch, cmd.pick, cmd.rd, cmd.exec}))
      else $error("more than one datapath command at once");

   // An update never overwrites a result that is still waiting.
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> (!rsp_valid || rsp_ready))
      else $error("result register overwritten while stalled");

   // A non-allocate request goes straight to the memory read.
   a_read_next : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_type == REQ_FREE || req_type == REQ_ACQUIRE ||
       req_type == REQ_RELEASE || req_type == REQ_CHECK || req_type == REQ_READ))
      |=> cmd.rd)
      else $error("memory read did not follow a lookup request");

   // One result cannot be both the first acquire and the last release.
   a_first_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_first_acquire && rsp_last_release))
      else $error("first acquire and last release flagged together");
`endif

endmodule

// ===== bench/generational_handle_table_tb.sv =====
// Self-checking testbench for the generational handle table.
`timescale 1ns / 1ps
module generational_handle_table_tb;
   import ght_pkg::*;

   // Request codes that the block accepts and drops without a result.
   localparam logic [2:0]  REQ_SPARE_LO = 3'd6;
   localparam logic [2:0]  REQ_SPARE_HI = 3'd7;
   // Appending stops one short of the null index.
   localparam int          APPEND_MAX   = 255;
   localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
   // Cycles without any transaction before the run is declared hung. The
   // longest legitimate silence is the receiver hold-off below.
   localparam int          IDLE_LIMIT   = 4000;
   localparam int          HOLD_CYCLES  = 300;
   localparam int          REPORT_MAX   = 10;
   localparam int          RANDOM_ITEMS = 620;
   localparam int          RUN_LENGTH   = 40;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  slot;
      logic [7:0]  gen;
      logic [15:0] count;
      logic        first;
      logic        last;
      logic        batch_last;
   } result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_type = 3'd0;
   logic [7:0]  req_slot_id = 8'd0;
   logic [7:0]  req_handle_gen = 8'd0;
   logic        req_batch_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_out_slot;
   logic [7:0]  rsp_out_gen;
   logic [15:0] rsp_ref_count_out;
   logic        rsp_first_acquire;
   logic        rsp_last_release;
   logic        rsp_batch_last_out;

   // Shadow copy of the table, updated as each request transaction is accepted.
   logic [7:0]  slot_gen_shadow [0:255];
   bit          slot_free_shadow [0:255];
   logic [15:0] slot_count_shadow [0:255];
   int          slots_used_shadow;

   result_type  expected_results [$];
   int          failures = 0;
   int          idle_cycles = 0;
   // When set, neither side idles at random.
   bit          steady_mode = 1'b0;
   // Raised by a test to make the receiver hold off for HOLD_CYCLES.
   bit          hold_request = 1'b0;
   int          hold_left = 0;

   always #6 clock = ~clock;

   generational_handle_table i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_slot_id        (req_slot_id),
      .req_handle_gen     (req_handle_gen),
      .req_batch_last     (req_batch_last),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_out_slot       (rsp_out_slot),
      .rsp_out_gen        (rsp_out_gen),
      .rsp_ref_count_out  (rsp_ref_count_out),
      .rsp_first_acquire  (rsp_first_acquire),
      .rsp_last_release   (rsp_last_release),
      .rsp_batch_last_out (rsp_batch_last_out)
   );

   // Applies one request to the shadow table and works out the result that the
   // block must return. Returns 0 for codes that produce no result.
   function automatic bit apply_request(input logic [2:0] code, input logic [7:0] id,
                                        input logic [7:0] hg, input logic bl,
                                        output result_type r);
      int i;
      r = '0;
      r.batch_last = bl;
      r.slot = id;
      if (code > REQ_READ) return 1'b0;

      if (code == REQ_ALLOC) begin
         r.slot = '0;
         // The lowest free slot is reused with its generation bumped.
         for (i = 0; i < slots_used_shadow; i++) begin
            if (slot_free_shadow[i]) begin
               slot_gen_shadow[i] = slot_gen_shadow[i] + 8'd1;
               slot_free_shadow[i] = 1'b0;
               slot_count_shadow[i] = '0;
               r.status = ST_OK;
               r.slot = i[7:0];
               r.gen = slot_gen_shadow[i];
               return 1'b1;
            end
         end
         if (slots_used_shadow < APPEND_MAX) begin
            i = slots_used_shadow;
            slot_gen_shadow[i] = '0;
            slot_free_shadow[i] = 1'b0;
            slot_count_shadow[i] = '0;
            slots_used_shadow++;
            r.status = ST_OK;
            r.slot = i[7:0];
         end else begin
            r.status = ST_FULL;
         end
         return 1'b1;
      end

      if (code == REQ_READ) begin
         if (id >= slots_used_shadow) begin
            r.status = ST_BADGEN;
         end else begin
            r.status = ST_OK;
            r.gen = slot_gen_shadow[id];
            r.count = slot_count_shadow[id];
         end
         return 1'b1;
      end

      // The remaining requests all carry a handle.
      if (id == NULL_ID) begin
         r.status = ST_NULL;
         return 1'b1;
      end
      if (id >= slots_used_shadow) begin
         r.status = ST_BADGEN;
         return 1'b1;
      end
      if (slot_gen_shadow[id] != hg) begin
         r.status = ST_BADGEN;
         r.gen = slot_gen_shadow[id];
         r.count = slot_count_shadow[id];
         return 1'b1;
      end

      r.status = ST_OK;
      case (code)
         REQ_FREE: begin
            if (slot_count_shadow[id] != '0) begin
               r.status = ST_REFD;
            end else if (slot_free_shadow[id]) begin
               r.status = ST_FREE;
            end else begin
               slot_free_shadow[id] = 1'b1;
               slot_gen_shadow[id] = slot_gen_shadow[id] + 8'd1;
            end
         end
         REQ_ACQUIRE: begin
            // The count saturates; the first acquire is flagged.
            if (slot_count_shadow[id] < COUNT_MAX) begin
               slot_count_shadow[id] = slot_count_shadow[id] + 16'd1;
               r.first = (slot_count_shadow[id] == 16'd1);
            end
         end
         REQ_RELEASE: begin
            if (slot_count_shadow[id] == '0) begin
               r.status = ST_NOTHELD;
            end else begin
               slot_count_shadow[id] = slot_count_shadow[id] - 16'd1;
               r.last = (slot_count_shadow[id] == '0);
            end
         end
         default: begin
            if (slot_free_shadow[id]) r.status = ST_FREE;
         end
      endcase
      r.gen = slot_gen_shadow[id];
      r.count = slot_count_shadow[id];
      return 1'b1;
   endfunction

   // Picks a handle for a random request. Most handles name a known slot with
   // its current generation; the rest are null or carry a random slot or generation.
   function automatic void pick_handle(output logic [7:0] id, output logic [7:0] hg);
      int roll;
      roll = $urandom_range(99);
      if (slots_used_shadow > 0 && roll < 80) begin
         id = 8'($urandom_range(slots_used_shadow - 1));
      end else if (roll < 88) begin
         id = NULL_ID;
      end else begin
         id = 8'($urandom_range(255));
      end
      if ($urandom_range(99) < 85) begin
         hg = slot_gen_shadow[id];
      end else begin
         hg = 8'($urandom_range(255));
      end
   endfunction

   // Offers one request transaction and waits until the block takes it. Valid
   // stays high from one item to the next unless a random gap is inserted.
   task automatic issue_request(input logic [2:0] code, input logic [7:0] id,
                                input logic [7:0] hg, input logic bl);
      result_type r;
      if (!steady_mode && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= code;
      req_slot_id <= id;
      req_handle_gen <= hg;
      req_batch_last <= bl;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (apply_request(code, id, hg, bl, r)) expected_results.push_back(r);
   endtask

   // The sender stops offering and waits until every result has come back.
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // Directed requests: empty table, null handles, the count life cycle,
   // stale generations, double free, access to a free slot and dropped codes.
   task automatic test_corner_requests();
      issue_request(REQ_READ, 8'd0, 8'd0, 1'b0);
      issue_request(REQ_CHECK, 8'd0, 8'd0, 1'b1);
      issue_request(REQ_FREE, NULL_ID, 8'hFF, 1'b0);
      issue_request(REQ_ACQUIRE, NULL_ID, 8'd0, 1'b1);
      issue_request(REQ_RELEASE, NULL_ID, 8'd0, 1'b0);
      issue_request(REQ_CHECK, NULL_ID, 8'd0, 1'b0);
      issue_request(REQ_ALLOC, 8'hFF, 8'hFF, 1'b1);
      issue_request(REQ_ALLOC, 8'd0, 8'd0, 1'b0);
      issue_request(REQ_RELEASE, 8'd0, 8'd0, 1'b1);
      issue_request(REQ_ACQUIRE, 8'd0, 8'd0, 1'b0);
      issue_request(REQ_ACQUIRE, 8'd0, 8'd0, 1'b1);
      issue_request(REQ_FREE, 8'd0, 8'd0, 1'b0);
      issue_request(REQ_RELEASE, 8'd0, 8'd0, 1'b0);
      issue_request(REQ_RELEASE, 8'd0, 8'd0, 1'b1);
      issue_request(REQ_ACQUIRE, 8'd0, 8'hFF, 1'b1);
      issue_request(REQ_FREE, 8'd0, 8'd0, 1'b0);
      issue_request(REQ_CHECK, 8'd0, 8'd1, 1'b0);
      issue_request(REQ_FREE, 8'd0, 8'd1, 1'b1);
      issue_request(REQ_ACQUIRE, 8'd0, 8'd1, 1'b0);
      issue_request(REQ_RELEASE, 8'd0, 8'd1, 1'b1);
      issue_request(REQ_READ, 8'd0, 8'd0, 1'b0);
      issue_request(REQ_SPARE_LO, 8'hA5, 8'h5A, 1'b1);
      issue_request(REQ_SPARE_HI, 8'h5A, 8'hA5, 1'b0);
      issue_request(REQ_ALLOC, 8'd0, 8'd0, 1'b0);
      issue_request(REQ_READ, NULL_ID, 8'd0, 1'b1);
   endtask

   // Allocates past the last appendable slot so the block reports full, then
   // touches the highest slot index.
   task automatic test_fill_table();
      repeat (APPEND_MAX + 3) begin
         issue_request(REQ_ALLOC, 8'($urandom_range(255)), 8'($urandom_range(255)),
                       1'($urandom_range(1)));
      end
      issue_request(REQ_ACQUIRE, 8'd254, slot_gen_shadow[254], 1'b1);
      issue_request(REQ_CHECK, 8'd254, slot_gen_shadow[254], 1'b0);
      issue_request(REQ_READ, 8'd254, 8'd0, 1'b1);
   endtask

   // With the table full, freeing and reallocating one slot cycles its
   // generation through the 8-bit wrap.
   task automatic test_generation_wrap();
      logic [7:0] target;
      logic [7:0] stale;
      target = 8'($urandom_range(1, 253));
      stale = slot_gen_shadow[target];
      repeat (130) begin
         issue_request(REQ_FREE, target, slot_gen_shadow[target], 1'($urandom_range(1)));
         issue_request(REQ_ALLOC, 8'($urandom_range(255)), 8'($urandom_range(255)),
                       1'($urandom_range(1)));
      end
      issue_request(REQ_CHECK, target, stale, 1'b0);
      issue_request(REQ_CHECK, target, slot_gen_shadow[target], 1'b1);
   endtask

   // Random traffic, mostly valid handles, with acquire and release batches.
   // Partway through the receiver holds off so the block fills and stalls its
   // input, and a later stretch runs with no idling at all.
   task automatic test_random_traffic(input int item_total);
      int         sent;
      int         roll;
      int         len;
      int         k;
      bit         held;
      bit         drained;
      logic [2:0] code;
      logic [7:0] id;
      logic [7:0] hg;
      sent = 0;
      held = 1'b0;
      drained = 1'b0;
      while (sent < item_total) begin
         steady_mode = (sent > item_total / 2) && (sent < (item_total * 3) / 4);
         if (!held && sent >= item_total / 3) begin
            hold_request = 1'b1;
            held = 1'b1;
         end
         if (!drained && sent >= (item_total * 2) / 3) begin
            wait_results_drained();
            drained = 1'b1;
         end
         if ($urandom_range(99) < 12) begin
            len = $urandom_range(2, 6);
            code = $urandom_range(1) ? REQ_ACQUIRE : REQ_RELEASE;
            for (k = 0; k < len; k++) begin
               pick_handle(id, hg);
               issue_request(code, id, hg, k == len - 1);
            end
            sent += len;
         end else begin
            roll = $urandom_range(99);
            if (roll < 15) code = REQ_ALLOC;
            else if (roll < 30) code = REQ_FREE;
            else if (roll < 52) code = REQ_ACQUIRE;
            else if (roll < 72) code = REQ_RELEASE;
            else if (roll < 84) code = REQ_CHECK;
            else if (roll < 94) code = REQ_READ;
            else if (roll < 97) code = REQ_SPARE_LO;
            else code = REQ_SPARE_HI;
            pick_handle(id, hg);
            issue_request(code, id, hg, $urandom_range(3) == 0);
            // Dropped codes do not count as stimulus.
            if (code <= REQ_READ) sent++;
         end
      end
      steady_mode = 1'b0;
   endtask

   // Raises one slot's count with a back-to-back run of acquires, releases it
   // down to zero, releases once more while unheld, then frees and checks it.
   task automatic test_count_run();
      logic [7:0] target;
      target = 8'd0;
      steady_mode = 1'b1;
      repeat (RUN_LENGTH) begin
         issue_request(REQ_ACQUIRE, target, slot_gen_shadow[target],
                       1'($urandom_range(1)));
      end
      while (slot_count_shadow[target] != '0) begin
         issue_request(REQ_RELEASE, target, slot_gen_shadow[target],
                       1'($urandom_range(1)));
      end
      issue_request(REQ_RELEASE, target, slot_gen_shadow[target], 1'b1);
      issue_request(REQ_FREE, target, slot_gen_shadow[target], 1'b0);
      issue_request(REQ_CHECK, target, slot_gen_shadow[target], 1'b1);
      steady_mode = 1'b0;
   endtask

   // Receiver: takes result transactions, compares each with the oldest
   // expectation and drives rsp_ready with random stalls or a long hold-off.
   always @(posedge clock) begin
      result_type observed;
      result_type wanted;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            observed = {rsp_status, rsp_out_slot, rsp_out_gen, rsp_ref_count_out,
                        rsp_first_acquire, rsp_last_release, rsp_batch_last_out};
            if (expected_results.size() == 0) begin
               failures++;
               if (failures <= REPORT_MAX) begin
                  $display("%0t: result with none expected: status %0d slot %0d gen %0d",
                           $realtime, observed.status, observed.slot, observed.gen);
               end
            end else begin
               wanted = expected_results.pop_front();
               if (observed.status !== wanted.status || observed.slot !== wanted.slot ||
                   observed.gen !== wanted.gen || observed.count !== wanted.count ||
                   observed.first !== wanted.first || observed.last !== wanted.last ||
                   observed.batch_last !== wanted.batch_last) begin
                  failures++;
                  if (failures <= REPORT_MAX) begin
                     $display({"%0t: mismatch expected st %0d slot %0d gen %0d cnt %0d ",
                               "first %0b last %0b bl %0b, got st %0d slot %0d gen %0d ",
                               "cnt %0d first %0b last %0b bl %0b"}, $realtime,
                              wanted.status, wanted.slot, wanted.gen, wanted.count,
                              wanted.first, wanted.last, wanted.batch_last,
                              observed.status, observed.slot, observed.gen,
                              observed.count, observed.first, observed.last,
                              observed.batch_last);
                  end
               end
            end
         end
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady_mode || ($urandom_range(99) >= 6);
         end
      end
   end

   // Watchdog: counts cycles in which no transaction happens on either side.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("generational_handle_table regression: fail");
            $finish;
         end
      end
   end

   initial begin
      int i;
      for (i = 0; i < 256; i++) begin
         slot_gen_shadow[i] = '0;
         slot_free_shadow[i] = 1'b0;
         slot_count_shadow[i] = '0;
      end
      slots_used_shadow = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_corner_requests();
      wait_results_drained();
      test_fill_table();
      wait_results_drained();
      test_generation_wrap();
      wait_results_drained();
      test_random_traffic(RANDOM_ITEMS);
      wait_results_drained();
      test_count_run();
      wait_results_drained();

      // Give any stray result time to show up before the verdict.
      repeat (20) @(posedge clock);
      if (failures == 0 && expected_results.size() == 0) begin
         $display("generational_handle_table regression: pass");
      end else begin
         $display("generational_handle_table regression: fail");
      end
      $finish;
   end

endmodule
